// ===== rtl/miller_rabin_prime_test_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef MILLER_RABIN_PRIME_TEST_UNIT_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_UNIT_DEFINES_SVH

// clocked property, ignored while reset is high
`define MRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked property, checked in and out of reset
`define MRP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/mrp_pkg.sv =====
`timescale 1ns / 1ps

package mrp_pkg;

   localparam int NUMBER_BITS = 63;
   localparam int BASE_COUNT  = 12;

   localparam int S_W    = $clog2(NUMBER_BITS);
   localparam int IDX_W  = $clog2(BASE_COUNT + 1);
   localparam int BASE_W = 6;
   localparam int PC_W   = 5;
   localparam int OP_W   = 4;
   localparam int COND_W = 4;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
   localparam logic [OP_W-1:0] OP_SHIFT_D    = 4'd1;
   localparam logic [OP_W-1:0] OP_LOAD_POW   = 4'd2;
   localparam logic [OP_W-1:0] OP_SUB_B      = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL_XB     = 4'd4;
   localparam logic [OP_W-1:0] OP_WB_X       = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_BB     = 4'd6;
   localparam logic [OP_W-1:0] OP_WB_B       = 4'd7;
   localparam logic [OP_W-1:0] OP_MUL_XX     = 4'd8;
   localparam logic [OP_W-1:0] OP_WB_X_K     = 4'd9;
   localparam logic [OP_W-1:0] OP_INC_IDX    = 4'd10;
   localparam logic [OP_W-1:0] OP_DONE_PRIME = 4'd11;
   localparam logic [OP_W-1:0] OP_DONE_COMP  = 4'd12;

   // branch conditions
   localparam logic [COND_W-1:0] C_NEVER        = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS       = 4'd1;
   localparam logic [COND_W-1:0] C_N_LT2        = 4'd2;
   localparam logic [COND_W-1:0] C_D_EVEN       = 4'd3;
   localparam logic [COND_W-1:0] C_N_EQ_BASE    = 4'd4;
   localparam logic [COND_W-1:0] C_B_GE_N       = 4'd5;
   localparam logic [COND_W-1:0] C_E_ZERO       = 4'd6;
   localparam logic [COND_W-1:0] C_E_ODD        = 4'd7;
   localparam logic [COND_W-1:0] C_X_ONE_OR_NM1 = 4'd8;
   localparam logic [COND_W-1:0] C_K_LT_S       = 4'd9;
   localparam logic [COND_W-1:0] C_X_NM1        = 4'd10;
   localparam logic [COND_W-1:0] C_IDX_LAST     = 4'd11;
   localparam logic [COND_W-1:0] C_MUL_BUSY     = 4'd12;

   // program addresses
   localparam logic [PC_W-1:0] A_START   = 5'd0;
   localparam logic [PC_W-1:0] A_STRIP   = 5'd1;
   localparam logic [PC_W-1:0] A_SHIFT   = 5'd2;
   localparam logic [PC_W-1:0] A_BASE    = 5'd3;
   localparam logic [PC_W-1:0] A_LOAD    = 5'd4;
   localparam logic [PC_W-1:0] A_REDUCE  = 5'd5;
   localparam logic [PC_W-1:0] A_SUB     = 5'd6;
   localparam logic [PC_W-1:0] A_POW     = 5'd7;
   localparam logic [PC_W-1:0] A_ODD     = 5'd8;
   localparam logic [PC_W-1:0] A_MXB     = 5'd9;
   localparam logic [PC_W-1:0] A_WAIT_XB = 5'd10;
   localparam logic [PC_W-1:0] A_WB_X    = 5'd11;
   localparam logic [PC_W-1:0] A_MBB     = 5'd12;
   localparam logic [PC_W-1:0] A_WAIT_BB = 5'd13;
   localparam logic [PC_W-1:0] A_WB_B    = 5'd14;
   localparam logic [PC_W-1:0] A_CHECK   = 5'd15;
   localparam logic [PC_W-1:0] A_SQUARE  = 5'd16;
   localparam logic [PC_W-1:0] A_MXX     = 5'd17;
   localparam logic [PC_W-1:0] A_WAIT_XX = 5'd18;
   localparam logic [PC_W-1:0] A_WB_XK   = 5'd19;
   localparam logic [PC_W-1:0] A_TEST_NM = 5'd20;
   localparam logic [PC_W-1:0] A_NEXT    = 5'd21;
   localparam logic [PC_W-1:0] A_INC     = 5'd22;
   localparam logic [PC_W-1:0] A_PRIME   = 5'd23;
   localparam logic [PC_W-1:0] A_COMP    = 5'd24;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic              neg;
      logic [PC_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic            load;
      logic            fire;
      logic [OP_W-1:0] op;
   } dp_ctrl_type;

   typedef struct packed {
      logic n_lt2;
      logic d_even;
      logic n_eq_base;
      logic b_ge_n;
      logic e_zero;
      logic e_odd;
      logic x_one_or_nm1;
      logic k_lt_s;
      logic x_nm1;
      logic idx_last;
      logic mul_busy;
   } dp_status_type;

   function automatic logic [BASE_W-1:0] base_value(input logic [IDX_W-1:0] idx);
      logic [BASE_W-1:0] v;
      case (idx)
         4'd0:    v = 6'd2;
         4'd1:    v = 6'd3;
         4'd2:    v = 6'd5;
         4'd3:    v = 6'd7;
         4'd4:    v = 6'd11;
         4'd5:    v = 6'd13;
         4'd6:    v = 6'd17;
         4'd7:    v = 6'd19;
         4'd8:    v = 6'd23;
         4'd9:    v = 6'd29;
         4'd10:   v = 6'd31;
         4'd11:   v = 6'd37;
         default: v = 6'd37;
      endcase
      return v;
   endfunction

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         A_START:   w = '{OP_NOP,        C_N_LT2,        1'b0, A_COMP};
         A_STRIP:   w = '{OP_NOP,        C_D_EVEN,       1'b1, A_BASE};
         A_SHIFT:   w = '{OP_SHIFT_D,    C_ALWAYS,       1'b0, A_STRIP};
         A_BASE:    w = '{OP_NOP,        C_N_EQ_BASE,    1'b0, A_PRIME};
         A_LOAD:    w = '{OP_LOAD_POW,   C_NEVER,        1'b0, A_START};
         A_REDUCE:  w = '{OP_NOP,        C_B_GE_N,       1'b1, A_POW};
         A_SUB:     w = '{OP_SUB_B,      C_ALWAYS,       1'b0, A_REDUCE};
         A_POW:     w = '{OP_NOP,        C_E_ZERO,       1'b0, A_CHECK};
         A_ODD:     w = '{OP_NOP,        C_E_ODD,        1'b1, A_MBB};
         A_MXB:     w = '{OP_MUL_XB,     C_NEVER,        1'b0, A_START};
         A_WAIT_XB: w = '{OP_NOP,        C_MUL_BUSY,     1'b0, A_WAIT_XB};
         A_WB_X:    w = '{OP_WB_X,       C_NEVER,        1'b0, A_START};
         A_MBB:     w = '{OP_MUL_BB,     C_NEVER,        1'b0, A_START};
         A_WAIT_BB: w = '{OP_NOP,        C_MUL_BUSY,     1'b0, A_WAIT_BB};
         A_WB_B:    w = '{OP_WB_B,       C_ALWAYS,       1'b0, A_POW};
         A_CHECK:   w = '{OP_NOP,        C_X_ONE_OR_NM1, 1'b0, A_NEXT};
         A_SQUARE:  w = '{OP_NOP,        C_K_LT_S,       1'b1, A_COMP};
         A_MXX:     w = '{OP_MUL_XX,     C_NEVER,        1'b0, A_START};
         A_WAIT_XX: w = '{OP_NOP,        C_MUL_BUSY,     1'b0, A_WAIT_XX};
         A_WB_XK:   w = '{OP_WB_X_K,     C_NEVER,        1'b0, A_START};
         A_TEST_NM: w = '{OP_NOP,        C_X_NM1,        1'b1, A_SQUARE};
         A_NEXT:    w = '{OP_NOP,        C_IDX_LAST,     1'b0, A_PRIME};
         A_INC:     w = '{OP_INC_IDX,    C_ALWAYS,       1'b0, A_BASE};
         A_PRIME:   w = '{OP_DONE_PRIME, C_NEVER,        1'b0, A_START};
         A_COMP:    w = '{OP_DONE_COMP,  C_NEVER,        1'b0, A_START};
         default:   w = '{OP_DONE_COMP,  C_NEVER,        1'b0, A_START};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/mrp_mulmod.sv =====
`timescale 1ns / 1ps

module mrp_mulmod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mrp_pkg::NUMBER_BITS-1:0] modulus,
   input  logic [mrp_pkg::NUMBER_BITS-1:0] op_a,
   input  logic [mrp_pkg::NUMBER_BITS-1:0] op_b,
   output logic                           busy,
   output logic [mrp_pkg::NUMBER_BITS-1:0] product
);
   import mrp_pkg::*;

   logic                   busy_ff, busy_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [NUMBER_BITS-1:0] x_ff, x_in;
   logic [NUMBER_BITS-1:0] y_ff, y_in;

   // (p + q) mod m for p, q < m, exact in one extra bit
   function automatic logic [NUMBER_BITS-1:0] add_mod(input logic [NUMBER_BITS-1:0] p,
                                                      input logic [NUMBER_BITS-1:0] q,
                                                      input logic [NUMBER_BITS-1:0] m);
      logic [NUMBER_BITS:0] t;
      logic [NUMBER_BITS:0] mm;
      logic [NUMBER_BITS:0] r;
      t  = {1'b0, p} + {1'b0, q};
      mm = {1'b0, m};
      r  = (t >= mm) ? (t - mm) : t;
      return r[NUMBER_BITS-1:0];
   endfunction

   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         x_in    = op_a;
         y_in    = op_b;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (y_ff[0]) begin
               acc_in = add_mod(acc_ff, x_ff, modulus);
            end
            x_in = add_mod(x_ff, x_ff, modulus);
            y_in = {1'b0, y_ff[NUMBER_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/mrp_datapath.sv =====
`timescale 1ns / 1ps

module mrp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  mrp_pkg::dp_ctrl_type            ctrl,
   input  logic [mrp_pkg::NUMBER_BITS-1:0] number,
   output mrp_pkg::dp_status_type          status
);
   import mrp_pkg::*;

   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [NUMBER_BITS-1:0] nm1_ff, nm1_in;
   logic [NUMBER_BITS-1:0] d_ff, d_in;
   logic [NUMBER_BITS-1:0] e_ff, e_in;
   logic [NUMBER_BITS-1:0] b_ff, b_in;
   logic [NUMBER_BITS-1:0] x_ff, x_in;
   logic [S_W-1:0]         s_ff, s_in;
   logic [S_W-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic [NUMBER_BITS-1:0] base_ext;
   logic                   mul_start;
   logic [NUMBER_BITS-1:0] mul_a;
   logic [NUMBER_BITS-1:0] mul_b;
   logic                   mul_busy;
   logic [NUMBER_BITS-1:0] mul_product;

   assign base_ext = {{(NUMBER_BITS-BASE_W){1'b0}}, base_value(idx_ff)};

   always_comb begin
      mul_start = 1'b0;
      mul_a     = x_ff;
      mul_b     = b_ff;
      if (ctrl.fire) begin
         case (ctrl.op)
            OP_MUL_XB: begin
               mul_start = 1'b1;
            end
            OP_MUL_BB: begin
               mul_start = 1'b1;
               mul_a     = b_ff;
            end
            OP_MUL_XX: begin
               mul_start = 1'b1;
               mul_b     = x_ff;
            end
            default: begin
               mul_start = 1'b0;
            end
         endcase
      end
   end

   mrp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .modulus (n_ff),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .product (mul_product)
   );

   always_comb begin
      n_in   = n_ff;
      nm1_in = nm1_ff;
      d_in   = d_ff;
      e_in   = e_ff;
      b_in   = b_ff;
      x_in   = x_ff;
      s_in   = s_ff;
      k_in   = k_ff;
      idx_in = idx_ff;
      if (ctrl.load) begin
         n_in   = number;
         nm1_in = number - 1'b1;
         d_in   = number - 1'b1;
         s_in   = '0;
         idx_in = '0;
      end else if (ctrl.fire) begin
         case (ctrl.op)
            OP_SHIFT_D: begin
               d_in = {1'b0, d_ff[NUMBER_BITS-1:1]};
               s_in = s_ff + 1'b1;
            end
            OP_LOAD_POW: begin
               b_in = base_ext;
               x_in = {{(NUMBER_BITS-1){1'b0}}, 1'b1};
               e_in = d_ff;
               k_in = {{(S_W-1){1'b0}}, 1'b1};
            end
            OP_SUB_B: begin
               b_in = b_ff - n_ff;
            end
            OP_WB_X: begin
               x_in = mul_product;
            end
            OP_WB_B: begin
               b_in = mul_product;
               e_in = {1'b0, e_ff[NUMBER_BITS-1:1]};
            end
            OP_WB_X_K: begin
               x_in = mul_product;
               k_in = k_ff + 1'b1;
            end
            OP_INC_IDX: begin
               idx_in = idx_ff + 1'b1;
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   // pure payload, every use follows a load
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      nm1_ff <= nm1_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      s_ff   <= s_in;
      k_ff   <= k_in;
      idx_ff <= idx_in;
   end

   always_comb begin
      status.n_lt2        = (n_ff[NUMBER_BITS-1:1] == '0);
      status.d_even       = (d_ff != '0) && !d_ff[0];
      status.n_eq_base    = (n_ff == base_ext);
      status.b_ge_n       = (b_ff >= n_ff);
      status.e_zero       = (e_ff == '0);
      status.e_odd        = e_ff[0];
      status.x_one_or_nm1 = (x_ff == {{(NUMBER_BITS-1){1'b0}}, 1'b1}) || (x_ff == nm1_ff);
      status.k_lt_s       = (k_ff < s_ff);
      status.x_nm1        = (x_ff == nm1_ff);
      status.idx_last     = (idx_ff == IDX_W'(BASE_COUNT - 1));
      status.mul_busy     = mul_busy;
   end

endmodule

// ===== rtl/mrp_sequencer.sv =====
`timescale 1ns / 1ps

module mrp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   out_free,
   input  mrp_pkg::dp_status_type status,
   output mrp_pkg::dp_ctrl_type   ctrl,
   output logic                   busy
);
   import mrp_pkg::*;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       word;
   logic            is_done;
   logic            hold;
   logic            fire;
   logic            cond_true;

   always_comb begin
      word    = ucode_rom(pc_ff);
      is_done = (word.op == OP_DONE_PRIME) || (word.op == OP_DONE_COMP);
      // a finished answer waits for the output register
      hold    = is_done && !out_free;
      fire    = busy_ff && !hold;
   end

   always_comb begin
      case (word.cond)
         C_NEVER:        cond_true = 1'b0;
         C_ALWAYS:       cond_true = 1'b1;
         C_N_LT2:        cond_true = status.n_lt2;
         C_D_EVEN:       cond_true = status.d_even;
         C_N_EQ_BASE:    cond_true = status.n_eq_base;
         C_B_GE_N:       cond_true = status.b_ge_n;
         C_E_ZERO:       cond_true = status.e_zero;
         C_E_ODD:        cond_true = status.e_odd;
         C_X_ONE_OR_NM1: cond_true = status.x_one_or_nm1;
         C_K_LT_S:       cond_true = status.k_lt_s;
         C_X_NM1:        cond_true = status.x_nm1;
         C_IDX_LAST:     cond_true = status.idx_last;
         C_MUL_BUSY:     cond_true = status.mul_busy;
         default:        cond_true = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = A_START;
      end else if (fire) begin
         if (is_done) begin
            busy_in = 1'b0;
            pc_in   = A_START;
         end else if (cond_true ^ word.neg) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= A_START;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctrl.load = start;
   assign ctrl.fire = fire;
   assign ctrl.op   = word.op;
   assign busy      = busy_ff;

endmodule

// ===== rtl/miller_rabin_prime_test_unit.sv =====
`timescale 1ns / 1ps
// channel  | ports                           | direction | content
// ---------+---------------------------------+-----------+-------------------------------
// request  | req_valid req_stall req_number  | in        | 63-bit candidate number
// response | rsp_valid rsp_stall rsp_is_prime| out       | 1 when the candidate is prime
//
// one candidate at a time; the test runs twelve bases, each up to ~124 modular products,
// each product a multiplier run plus microcode steps; below 2, equal to a base or even
// ones finish much sooner
// the time is set by the single shift-and-add modular multiplier, one operand bit per cycle
// reset is synchronous and active high; no clearing pass, the block is ready right after it
// req_stall is high while a number is being tested; a stalled response holds the
// program at its final step but the next request is taken as soon as the test ends

module miller_rabin_prime_test_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mrp_pkg::NUMBER_BITS-1:0] req_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_prime
);
   import mrp_pkg::*;

   // sequencer <-> datapath
   dp_ctrl_type   ctrl;
   dp_status_type status;
   logic          seq_busy;

   logic          req_xfer;
   logic          out_free;
   logic          done_fire;

   // output register, parts the response side from the sequencer
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_is_prime_ff, rsp_is_prime_in;

   assign req_stall = seq_busy;
   assign req_xfer  = req_valid && !seq_busy;
   // the output register can take a new answer if empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   mrp_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .out_free (out_free),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (seq_busy)
   );

   mrp_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .number (req_number),
      .status (status)
   );

   // final program step, verdict is in the opcode
   assign done_fire = ctrl.fire && ((ctrl.op == OP_DONE_PRIME) || (ctrl.op == OP_DONE_COMP));

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done_fire) begin
         rsp_valid_in    = 1'b1;
         rsp_is_prime_in = (ctrl.op == OP_DONE_PRIME);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

// ===== rtl/mrp_checker.sv =====
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_unit_defines.svh"

module mrp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_is_prime
);

   // a stalled response keeps its verdict
   `MRP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_prime), "stalled response changed")

   // a new request closes the input until the test ends
   `MRP_ASSERT(a_req_closes, req_valid && !req_stall |=> req_stall, "request taken while busy")

   // a fresh response appears only as a test ends
   `MRP_ASSERT(a_rsp_from_test, $rose(rsp_valid) |-> $fell(req_stall), "response without a finished test")

   // the input is open and no response is waiting after reset
   `MRP_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !req_stall && !rsp_valid, "busy after reset")

endmodule

bind miller_rabin_prime_test_unit mrp_checker u_mrp_checker (.*);

// ===== tb/sv/tb_miller_rabin_prime_test_unit.sv =====
`timescale 1ns / 1ps

module tb_miller_rabin_prime_test_unit;

   localparam int NB = mrp_pkg::NUMBER_BITS;

   // quiet cycles allowed with no transfer on either channel; covers the slowest
   // candidate plus the long result hold-off below
   localparam int WATCHDOG_LIMIT = 1_000_000;
   // the result channel holds off once for this long after that many results
   localparam int LONG_HOLD      = 60_000;
   localparam int HOLD_AFTER     = 30;
   // cycles kept running after the last verdict to catch a stray result
   localparam int DRAIN_CYCLES   = 2_000;
   localparam int RANDOM_COUNT   = 80;

   // witness bases in test order, index 0 first
   localparam logic [11:0][7:0] WITNESS_BASES = {
      8'd37, 8'd31, 8'd29, 8'd23, 8'd19, 8'd17,
      8'd13, 8'd11, 8'd7,  8'd5,  8'd3,  8'd2
   };

   typedef struct {
      logic [NB-1:0] number;
      bit            drain_first;   // sender waits for all verdicts before this one
   } candidate_type;

   typedef struct {
      logic [NB-1:0] number;
      logic          is_prime;
   } verdict_type;

   logic          clock;
   logic          reset      = 1'b1;
   logic          req_valid  = 1'b0;
   logic          req_stall;
   logic [NB-1:0] req_number = '0;
   logic          rsp_valid;
   logic          rsp_stall  = 1'b0;
   logic          rsp_is_prime;

   candidate_type pending_candidates[$];
   verdict_type   expected_verdicts[$];

   // sender state, touched only by the driver
   bit            offering     = 1'b0;
   logic [NB-1:0] offer_number = '0;
   int            send_gap     = 0;
   candidate_type next_candidate;

   // receiver state, touched only by the monitor
   int          results_seen = 0;
   int          hold_left    = 0;
   int          rx_left      = 0;
   bit          rx_stalled   = 1'b0;
   bit          stalling;
   verdict_type oldest;

   int mismatches  = 0;
   int idle_cycles = 0;

   miller_rabin_prime_test_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // primality predictor: exact modular products through a 128-bit
   // intermediate, then the usual strong-probable-prime test per base
   // ------------------------------------------------------------------
   function automatic logic [63:0] mul_residue(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] pow_residue(input logic [63:0] b, input logic [63:0] e,
                                               input logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] ex;
      acc = 64'd1 % m;
      sq  = b % m;
      ex  = e;
      while (ex != 0) begin
         if (ex[0])
            acc = mul_residue(acc, sq, m);
         sq = mul_residue(sq, sq, m);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic logic predict_is_prime(input logic [NB-1:0] cand);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] x;
      int          s;
      bit          witness;
      n = 64'(cand);
      if (n < 2)
         return 1'b0;
      // n - 1 = d * 2^s
      d = n - 1;
      s = 0;
      while (d != 0 && !d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < mrp_pkg::BASE_COUNT && i < 12; i++) begin
         if (n == 64'(WITNESS_BASES[i]))
            return 1'b1;
         x = pow_residue(64'(WITNESS_BASES[i]), d, n);
         if (x == 1 || x == n - 1)
            continue;
         witness = 1'b1;
         for (int k = 1; k < s; k++) begin
            x = mul_residue(x, x, n);
            if (x == n - 1) begin
               witness = 1'b0;
               break;
            end
         end
         if (witness)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 20);
      return $urandom_range(50, 400);
   endfunction

   // random candidate: mostly narrow (the test time grows with the width),
   // mostly odd so the full base sweep runs instead of the quick even exit
   function automatic logic [NB-1:0] random_candidate();
      int          r;
      int          width;
      logic [63:0] raw;
      r = $urandom_range(0, 99);
      if (r < 80)
         width = $urandom_range(2, 20);
      else if (r < 96)
         width = $urandom_range(21, 40);
      else
         width = $urandom_range(41, NB);
      raw = {$urandom, $urandom};
      raw = raw & ((64'd1 << width) - 1);
      raw[width-1] = 1'b1;
      if ($urandom_range(0, 9) != 0)
         raw[0] = 1'b1;
      return raw[NB-1:0];
   endfunction

   task automatic queue_candidate(input logic [NB-1:0] number, input bit drain_first);
      candidate_type c;
      c.number      = number;
      c.drain_first = drain_first;
      pending_candidates.push_back(c);
   endtask

   // ------------------------------------------------------------------
   // request driver: offers queued candidates with random gaps; a valid
   // stays up with a steady number until the transfer happens
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_number <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            // request transfer: record the verdict the block owes us
            expected_verdicts.push_back('{number: req_number,
                                          is_prime: predict_is_prime(req_number)});
            offering = 1'b0;
            send_gap = pick_gap();
         end
         if (!offering) begin
            if (send_gap > 0)
               send_gap--;
            else if (pending_candidates.size() > 0 &&
                     !(pending_candidates[0].drain_first && expected_verdicts.size() > 0)) begin
               next_candidate = pending_candidates.pop_front();
               offer_number   = next_candidate.number;
               offering       = 1'b1;
            end
         end
         req_valid  <= offering;
         req_number <= offer_number;
      end
   end

   // ------------------------------------------------------------------
   // response monitor: checks each result transfer against the oldest
   // verdict and drives rsp_stall, including one long hold-off so the
   // block ends up with a finished result and a pending request at once
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result transfer: expected none, got is_prime=%0d",
                        $time, rsp_is_prime);
               mismatches++;
            end else begin
               oldest = expected_verdicts.pop_front();
               if (rsp_is_prime !== oldest.is_prime) begin
                  $display("%0t: is_prime mismatch for %0d: expected %0d, got %0d",
                           $time, oldest.number, oldest.is_prime, rsp_is_prime);
                  mismatches++;
               end
            end
            results_seen++;
            if (results_seen == HOLD_AFTER)
               hold_left = LONG_HOLD;
         end

         if (hold_left > 0) begin
            hold_left--;
            stalling = 1'b1;
         end else begin
            // alternate stall runs and free runs of random length
            if (rx_left == 0) begin
               rx_stalled = !rx_stalled;
               rx_left    = rx_stalled ? pick_gap() : $urandom_range(0, 300);
            end else begin
               rx_left--;
            end
            stalling = rx_stalled;
         end
         rsp_stall <= stalling;
      end
   end

   // watchdog: cycles in a row with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      // below two
      queue_candidate(63'd0, 1'b0);
      queue_candidate(63'd1, 1'b0);
      // every base, each caught by the equal-to-base exit
      for (int i = 0; i < 12; i++)
         queue_candidate(NB'(WITNESS_BASES[i]), 1'b0);
      // small even number and a square of a base
      queue_candidate(63'd4, 1'b0);
      queue_candidate(63'd9, 1'b0);
      // carmichael number and strong pseudoprimes to the leading bases
      queue_candidate(63'd561, 1'b0);
      queue_candidate(63'd3215031751, 1'b0);
      queue_candidate(63'd3825123056546413051, 1'b0);
      // large primes: mersenne 2^61-1 and the largest below 2^63
      queue_candidate(63'd2305843009213693951, 1'b0);
      queue_candidate(63'd9223372036854775783, 1'b0);
      // all ones, and the largest even value
      queue_candidate(63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      queue_candidate(63'h7FFF_FFFF_FFFF_FFFE, 1'b0);

      // random part; one candidate waits until the block has drained
      for (int i = 0; i < RANDOM_COUNT; i++)
         queue_candidate(random_candidate(), i == RANDOM_COUNT / 2);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // run until every candidate went out and every verdict came back
      @(posedge clock);
      while (!(pending_candidates.size() == 0 && !offering && expected_verdicts.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d verdicts outstanding",
                  $time, expected_verdicts.size());
         $display("[FAIL] regression broken");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("[ OK ] regression clean");
         end else begin
            $display("[FAIL] regression broken");
         end
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrp_pkg.sv
rtl/mrp_mulmod.sv
rtl/mrp_datapath.sv
rtl/mrp_sequencer.sv
rtl/miller_rabin_prime_test_unit.sv
rtl/mrp_checker.sv
tb/sv/tb_miller_rabin_prime_test_unit.sv
